[hw/rtl/fesc_pkg.sv]
// Shared constants and the front-to-back command type of the flag-escape codec.
package fesc_pkg;

    // Frame flag, escape byte and the two escape codes
    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] ESC_BYTE  = 8'h7d;
    localparam logic [7:0] ESC_FLAG  = 8'h02;
    localparam logic [7:0] ESC_ESC   = 8'h01;

    // Width of the reported frame length
    localparam int OUT_LEN_W = 14;

    // Command queue depth and its pointer width
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // One accepted item's worth of output: one or two bytes plus frame status
    typedef struct packed {
        logic [7:0]           byte0;
        logic [7:0]           byte1;
        logic                 two;
        logic                 fin;
        logic                 err;
        logic [OUT_LEN_W-1:0] len;
    } fesc_cmd_t;

endpackage

[hw/rtl/flag_escape_byte_stuffing_codec.sv]
// Top level of the 0x7e/0x7d flag-escape byte-stuffing codec.
// Frame bytes enter one item per cycle on the s_ channel while s_ready is high and leave
// as result items on the m_ channel, one byte per cycle while m_ready is high. An item
// that yields no byte (a held escape) pushes no command, and one that yields two bytes
// (an escape pair, or a held escape flushed before a byte) occupies the output stage for
// both, which sets the sustained rate. The front end classifies each byte and pushes a
// command into a four-entry queue, so it keeps accepting through output stalls until
// the queue fills; each result passes the queue entry and output register.
// cfg_wr_en/cfg_wr_data set the direction (0 encode, 1 decode) and must only be written
// while the codec is idle. A bad first or last flag raises m_error on the frame's final
// result, which also carries the saturating byte count.
module flag_escape_byte_stuffing_codec #(
    parameter int COUNT_BITS = 14
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_byte_in,
    input  logic                           s_frame_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_byte_out,
    output logic                           m_run_last,
    output logic                           m_frame_done,
    output logic                           m_error,
    output logic [fesc_pkg::OUT_LEN_W-1:0] m_out_length
);
    import fesc_pkg::*;

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_empty;
    fesc_cmd_t q_cmd;
    fesc_cmd_t q_head;

    // Accept and classify items
    fesc_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_byte_in   (s_byte_in),
        .s_frame_end (s_frame_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    // Buffer commands
    fesc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Emit result items
    fesc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_out   (m_byte_out),
        .m_run_last   (m_run_last),
        .m_frame_done (m_frame_done),
        .m_error      (m_error),
        .m_out_length (m_out_length)
    );

endmodule

[hw/rtl/fesc_front.sv]
// Front end: accepts input items, tracks frame state and builds output commands.
module fesc_front #(
    parameter int COUNT_BITS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_in,
    input  logic               s_frame_end,
    input  logic               q_full,
    output logic               q_push,
    output fesc_pkg::fesc_cmd_t q_cmd
);
    import fesc_pkg::*;

    localparam longint unsigned CountLimit =
        (COUNT_BITS >= OUT_LEN_W) ? 64'd16383 : ((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [COUNT_BITS:0] CntLimit = CountLimit[COUNT_BITS:0];

    logic                  direction_reg;
    logic                  at_start_reg, at_start_next;
    logic                  esc_pend_reg, esc_pend_next;
    logic                  bad_start_reg, bad_start_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  accept;
    logic                  dec;
    logic [7:0]            b0, b1;
    logic [1:0]            nbytes;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] count_sat;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign dec     = (direction_reg == DIR_DECODE);

    // Classify the byte and pick the output bytes
    always_comb begin
        b0            = s_byte_in;
        b1            = s_byte_in;
        nbytes        = 2'd1;
        esc_pend_next = esc_pend_reg;
        if (at_start_reg) begin
            nbytes = 2'd1;
        end else if (s_frame_end) begin
            if (dec && esc_pend_reg) begin
                b0     = ESC_BYTE;
                nbytes = 2'd2;
            end
        end else if (dec) begin
            if (esc_pend_reg) begin
                if (s_byte_in == ESC_FLAG) begin
                    b0            = FLAG_BYTE;
                    esc_pend_next = 1'b0;
                end else if (s_byte_in == ESC_ESC) begin
                    b0            = ESC_BYTE;
                    esc_pend_next = 1'b0;
                end else if (s_byte_in == ESC_BYTE) begin
                    b0 = ESC_BYTE;
                end else begin
                    b0            = ESC_BYTE;
                    nbytes        = 2'd2;
                    esc_pend_next = 1'b0;
                end
            end else if (s_byte_in == ESC_BYTE) begin
                nbytes        = 2'd0;
                esc_pend_next = 1'b1;
            end
        end else begin
            if (s_byte_in == FLAG_BYTE) begin
                b0     = ESC_BYTE;
                b1     = ESC_FLAG;
                nbytes = 2'd2;
            end else if (s_byte_in == ESC_BYTE) begin
                b0     = ESC_BYTE;
                b1     = ESC_ESC;
                nbytes = 2'd2;
            end
        end
        if (s_frame_end) begin
            esc_pend_next = 1'b0;
        end
    end

    // Advance the saturating byte count
    assign sum       = {1'b0, count_reg} + {{(COUNT_BITS-1){1'b0}}, nbytes};
    assign count_sat = (sum > CntLimit) ? CntLimit[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];

    // Frame state updates
    always_comb begin
        at_start_next  = at_start_reg;
        bad_start_next = bad_start_reg;
        count_next     = count_sat;
        if (at_start_reg) begin
            at_start_next = 1'b0;
            if (s_byte_in != FLAG_BYTE) begin
                bad_start_next = 1'b1;
            end
        end
        if (s_frame_end) begin
            at_start_next  = 1'b1;
            bad_start_next = 1'b0;
            count_next     = '0;
        end
    end

    // Build the command for the queue
    always_comb begin
        q_push      = accept && (nbytes != 2'd0);
        q_cmd.byte0 = b0;
        q_cmd.byte1 = b1;
        q_cmd.two   = (nbytes == 2'd2);
        q_cmd.fin   = s_frame_end;
        q_cmd.err   = s_frame_end && (bad_start_reg || (s_byte_in != FLAG_BYTE));
        q_cmd.len   = s_frame_end ? OUT_LEN_W'(count_sat) : '0;
    end

    // Hold configuration and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_ENCODE;
            at_start_reg  <= 1'b1;
            esc_pend_reg  <= 1'b0;
            bad_start_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                direction_reg <= cfg_wr_data;
            end
            if (accept) begin
                at_start_reg  <= at_start_next;
                esc_pend_reg  <= esc_pend_next;
                bad_start_reg <= bad_start_next;
                count_reg     <= count_next;
            end
        end
    end

endmodule

[hw/rtl/fesc_queue.sv]
// Short command queue between the front end and the output stage.
module fesc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fesc_pkg::fesc_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output fesc_pkg::fesc_cmd_t head
);
    import fesc_pkg::*;

    fesc_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/fesc_back.sv]
// Output stage: splits each command into one or two result items.
module fesc_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_empty,
    input  fesc_pkg::fesc_cmd_t       q_head,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_byte_out,
    output logic                      m_run_last,
    output logic                      m_frame_done,
    output logic                      m_error,
    output logic [fesc_pkg::OUT_LEN_W-1:0] m_out_length
);
    import fesc_pkg::*;

    logic                 valid_reg;
    logic                 second_reg, second_next;
    logic                 load;
    logic                 last;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg;
    logic                 done_reg;
    logic                 err_reg;
    logic [OUT_LEN_W-1:0] len_reg;

    assign load = (!valid_reg || m_ready) && !q_empty;

    // Pick the next byte of the head command
    always_comb begin
        last        = second_reg || !q_head.two;
        byte_next   = second_reg ? q_head.byte1 : q_head.byte0;
        second_next = load ? !last : second_reg;
        q_pop       = load && last;
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            second_reg <= second_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Hold result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            last_reg <= last;
            done_reg <= last && q_head.fin;
            err_reg  <= last && q_head.err;
            len_reg  <= last ? q_head.len : '0;
        end
    end

    assign m_valid      = valid_reg;
    assign m_byte_out   = byte_reg;
    assign m_run_last   = last_reg;
    assign m_frame_done = done_reg;
    assign m_error      = err_reg;
    assign m_out_length = len_reg;

endmodule
